>>> hw/rtl/cmfuv_pkg.sv
// Shared constants for the cube-map face and coordinate block.
// No dependencies; used by cube_map_face_uv.
`default_nettype none
package cmfuv_pkg;
   localparam logic [2:0] FACE_RIGHT  = 3'd0;
   localparam logic [2:0] FACE_LEFT   = 3'd1;
   localparam logic [2:0] FACE_TOP    = 3'd2;
   localparam logic [2:0] FACE_BOTTOM = 3'd3;
   localparam logic [2:0] FACE_BACK   = 3'd4;
   localparam logic [2:0] FACE_FRONT  = 3'd5;
endpackage
`default_nettype wire

>>> hw/rtl/cmfuv_div_cell.sv
// One restoring-division cell: produces one quotient bit for both coordinates.
// Depends on nothing but its parameters; chained by cube_map_face_uv.
`default_nettype none
module cmfuv_div_cell #(
   parameter int MW = 18,
   parameter int QW = 17
) (
   input  wire logic          clock,
   input  wire logic          advance,
   input  wire logic [MW-1:0] div_in,
   input  wire logic [MW-1:0] rem_u_in,
   input  wire logic [MW-1:0] rem_v_in,
   input  wire logic [QW-1:0] q_u_in,
   input  wire logic [QW-1:0] q_v_in,
   input  wire logic [2:0]    face_in,
   input  wire logic          zero_in,
   output logic      [MW-1:0] div_out,
   output logic      [MW-1:0] rem_u_out,
   output logic      [MW-1:0] rem_v_out,
   output logic      [QW-1:0] q_u_out,
   output logic      [QW-1:0] q_v_out,
   output logic      [2:0]    face_out,
   output logic               zero_out
);
   logic [MW:0] sh_u, sh_v;
   logic        ge_u, ge_v;

   // Remainders never exceed the divisor, so the shifted value needs one more bit.
   assign sh_u = {rem_u_in, 1'b0};
   assign sh_v = {rem_v_in, 1'b0};
   assign ge_u = sh_u >= {1'b0, div_in};
   assign ge_v = sh_v >= {1'b0, div_in};

   always_ff @(posedge clock) begin
      if (advance) begin
         div_out   <= div_in;
         rem_u_out <= ge_u ? MW'(sh_u - {1'b0, div_in}) : sh_u[MW-1:0];
         rem_v_out <= ge_v ? MW'(sh_v - {1'b0, div_in}) : sh_v[MW-1:0];
         q_u_out   <= {q_u_in[QW-2:0], ge_u};
         q_v_out   <= {q_v_in[QW-2:0], ge_v};
         face_out  <= face_in;
         zero_out  <= zero_in;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/cube_map_face_uv.sv
// Top level of the cube-map face selector with face coordinates.
// Depends on cmfuv_pkg and cmfuv_div_cell.
//
//   Channel | Ports                                       | Direction
//   --------+---------------------------------------------+----------
//   request | req_valid req_ready req_dir_x/y/z           | in
//   result  | rsp_valid rsp_ready rsp_face rsp_u/v_coord  | out
//           | rsp_zero_vector                             |
//
// One direction is taken per cycle unless the chain stalls. There is one
// front stage (magnitudes, face pick, numerator set-up), UV_BITS division
// cells that each yield one quotient bit of u and v, and one output register.
// The whole chain advances together whenever the output register is empty
// or its result is being taken, so a stalled consumer freezes the chain.
// Synchronous reset clears only the valid bits of the stages.
`default_nettype none
module cube_map_face_uv
   import cmfuv_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int UV_BITS    = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [COORD_BITS-1:0] req_dir_x,
   input  wire logic [COORD_BITS-1:0] req_dir_y,
   input  wire logic [COORD_BITS-1:0] req_dir_z,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [2:0]                 rsp_face,
   output logic [UV_BITS-1:0]         rsp_u_coord,
   output logic [UV_BITS-1:0]         rsp_v_coord,
   output logic                       rsp_zero_vector
);
   // Magnitudes take COORD_BITS bits; divisor 2m and numerators c+m one more.
   localparam int MW    = COORD_BITS + 1;
   localparam int QW    = UV_BITS;
   localparam int CELLS = UV_BITS;

   logic advance;
   logic [CELLS+1:0] vld_ff;
   logic [CELLS+1:0] vld_in;

   logic signed [COORD_BITS:0] sx, sy, sz, uc, vc;
   logic [COORD_BITS:0] ax, ay, az, mg;
   logic ymaj, zmaj;
   logic [2:0] face_sel;

   logic [MW-1:0] div_c [CELLS+1];
   logic [MW-1:0] ru_c  [CELLS+1];
   logic [MW-1:0] rv_c  [CELLS+1];
   logic [QW-1:0] qu_c  [CELLS+1];
   logic [QW-1:0] qv_c  [CELLS+1];
   logic [2:0]    fc_c  [CELLS+1];
   logic          zr_c  [CELLS+1];

   logic [UV_BITS-1:0] u_sat, v_sat;

   // The chain moves as one; it stalls only while an unclaimed result is held.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign sx = {req_dir_x[COORD_BITS-1], req_dir_x};
   assign sy = {req_dir_y[COORD_BITS-1], req_dir_y};
   assign sz = {req_dir_z[COORD_BITS-1], req_dir_z};
   assign ax = sx[COORD_BITS] ? (COORD_BITS+1)'(0) - sx : sx;
   assign ay = sy[COORD_BITS] ? (COORD_BITS+1)'(0) - sy : sy;
   assign az = sz[COORD_BITS] ? (COORD_BITS+1)'(0) - sz : sz;
   assign ymaj = (ay >= ax) && (ay >= az);
   assign zmaj = (az >= ax) && (az >= ay);

   // Earlier tests win, so z has priority over y and y over x. Zero is negative.
   always_comb begin
      priority if (zmaj) begin
         mg = az;
         vc = -sy;
         if (sz > 0) begin
            uc = sx;
            face_sel = FACE_BACK;
         end else begin
            uc = -sx;
            face_sel = FACE_FRONT;
         end
      end else if (ymaj) begin
         mg = ay;
         uc = sx;
         vc = sz;
         face_sel = (sy > 0) ? FACE_TOP : FACE_BOTTOM;
      end else begin
         mg = ax;
         vc = -sy;
         if (sx > 0) begin
            uc = -sz;
            face_sel = FACE_RIGHT;
         end else begin
            uc = sz;
            face_sel = FACE_LEFT;
         end
      end
   end

   // Front stage. The numerator c+m never exceeds the divisor 2m, so the
   // first cell compares 2(c+m) against 2m and yields the first fraction bit.
   always_ff @(posedge clock) begin
      if (advance) begin
         div_c[0] <= MW'({mg, 1'b0});
         ru_c[0]  <= MW'(uc + $signed(mg));
         rv_c[0]  <= MW'(vc + $signed(mg));
         qu_c[0]  <= '0;
         qv_c[0]  <= '0;
         fc_c[0]  <= face_sel;
         zr_c[0]  <= (mg == '0);
      end
   end

   // After UV_BITS cells the quotient is floor((c+m)*2^UV_BITS/(2m)) for
   // c below m. When c equals m the remainder stays at the divisor and every
   // bit comes out one, which is the saturated value.
   genvar gi;
   generate
      for (gi = 0; gi < CELLS; gi++) begin : g_cell
         cmfuv_div_cell #(.MW(MW), .QW(QW)) u_cell (
            .clock     (clock),
            .advance   (advance),
            .div_in    (div_c[gi]),
            .rem_u_in  (ru_c[gi]),
            .rem_v_in  (rv_c[gi]),
            .q_u_in    (qu_c[gi]),
            .q_v_in    (qv_c[gi]),
            .face_in   (fc_c[gi]),
            .zero_in   (zr_c[gi]),
            .div_out   (div_c[gi+1]),
            .rem_u_out (ru_c[gi+1]),
            .rem_v_out (rv_c[gi+1]),
            .q_u_out   (qu_c[gi+1]),
            .q_v_out   (qv_c[gi+1]),
            .face_out  (fc_c[gi+1]),
            .zero_out  (zr_c[gi+1])
         );
      end
   endgenerate

   assign u_sat = qu_c[CELLS];
   assign v_sat = qv_c[CELLS];

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_face        <= fc_c[CELLS];
         rsp_zero_vector <= zr_c[CELLS];
         rsp_u_coord     <= zr_c[CELLS] ? '0 : u_sat;
         rsp_v_coord     <= zr_c[CELLS] ? '0 : v_sat;
      end
   end

   // One valid bit per register stage: front stage, each cell, output.
   always_comb begin
      vld_in = vld_ff;
      if (advance) begin
         vld_in = {vld_ff[CELLS:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[CELLS+1];

   // A stalled result must hold its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_u_coord) && $stable(rsp_face))
      else $error("result changed while stalled");
   // A zero vector always reports zero coordinates.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_u_coord == '0 && rsp_v_coord == '0)
      else $error("zero vector with nonzero coordinates");
   // Face codes stay within the six faces.
   a_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_face <= FACE_FRONT)
      else $error("face out of range");
   // The input side is ready whenever the output side is not stalled.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled without output stall");
endmodule
`default_nettype wire
